### src/pru_pkg.sv
// Shared constants, codes and types of the pixel replication upscaler.
`timescale 1ns / 1ps

package pru_pkg;

   // Default sizing of the line store and the replication limit
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_MAX_SCALE = 100;

   // Field widths fixed by the interface
   localparam int CHAN_W  = 8;
   localparam int PIXEL_W = 3 * CHAN_W;
   localparam int SCALE_W = 7;
   localparam int WIDTH_W = 11;
   localparam int KIND_W  = 2;
   localparam int PAD_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = WIDTH_W;

   // Operation codes of an input word
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_PULL = 1'b1;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH = 1'b1;

   // Register reset values
   localparam logic [SCALE_W-1:0] SCALE_RESET = 7'd1;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd1;

   // Control part of one result word
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              line_end;
      logic [PAD_W-1:0]  pad_bytes;
      logic              group_end;
   } rsp_ctl_type;

endpackage

### src/pru_line_store.sv
// Line store: one synchronous memory holding a source row, registered read port.
`timescale 1ns / 1ps

module pru_line_store
   import pru_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [PIXEL_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [PIXEL_W-1:0] rd_data
);

   logic [PIXEL_W-1:0] store_ff [MAX_WIDTH];
   logic [PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/pru_seq.sv
// Load and drain sequencer: column, copy and repeat counters, store requests.
`timescale 1ns / 1ps

module pru_seq
   import pru_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_SCALE = DEF_MAX_SCALE,
   parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               op,
   input  logic [PIXEL_W-1:0] pixel,
   input  logic [SCALE_W-1:0] scale_factor,
   input  logic [WIDTH_W-1:0] source_width,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [PIXEL_W-1:0] wr_data,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr,
   output rsp_ctl_type        ctl
);

   localparam int CW  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int SEW = $clog2(MAX_SCALE + 1);

   logic          draining_ff, draining_in;
   logic [AW-1:0] load_col_ff, load_col_in;
   logic [AW-1:0] drain_col_ff, drain_col_in;
   logic [CW-1:0] copy_ff, copy_in;
   logic [CW-1:0] repeat_ff, repeat_in;

   logic [WW-1:0]  weff;
   logic [SEW-1:0] seff;
   logic [AW-1:0]  wm1;
   logic [CW-1:0]  sm1;
   logic [PAD_W-1:0] pad;

   // Clamp the registers to their usable ranges
   always_comb begin
      if (source_width == '0) begin
         weff = WW'(1);
      end else if (32'(source_width) > MAX_WIDTH) begin
         weff = WW'(MAX_WIDTH);
      end else begin
         weff = WW'(source_width);
      end
      if (scale_factor == '0) begin
         seff = SEW'(1);
      end else if (32'(scale_factor) > MAX_SCALE) begin
         seff = SEW'(MAX_SCALE);
      end else begin
         seff = SEW'(scale_factor);
      end
   end

   assign wm1 = AW'(weff - WW'(1));
   assign sm1 = CW'(seff - SEW'(1));
   assign pad = PAD_W'(PAD_W'(weff) * PAD_W'(seff));

   assign wr_addr = load_col_ff;
   assign wr_data = pixel;
   assign rd_addr = drain_col_ff;

   always_comb begin
      draining_in  = draining_ff;
      load_col_in  = load_col_ff;
      drain_col_in = drain_col_ff;
      copy_in      = copy_ff;
      repeat_in    = repeat_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      ctl          = '{kind: KIND_NONE, line_end: 1'b0, pad_bytes: '0, group_end: 1'b0};
      if (accept) begin
         if (op == OP_LOAD) begin
            if (draining_ff) begin
               ctl.kind = KIND_REJECT;
            end else begin
               wr_en = 1'b1;
               if (load_col_ff >= wm1) begin
                  draining_in  = 1'b1;
                  drain_col_in = '0;
                  copy_in      = '0;
                  repeat_in    = '0;
               end else begin
                  load_col_in = load_col_ff + AW'(1);
               end
            end
         end else if (draining_ff) begin
            rd_en    = 1'b1;
            ctl.kind = KIND_PIXEL;
            if (copy_ff >= sm1) begin
               copy_in = '0;
               if (drain_col_ff >= wm1) begin
                  ctl.line_end  = 1'b1;
                  ctl.pad_bytes = pad;
                  drain_col_in  = '0;
                  if (repeat_ff >= sm1) begin
                     ctl.group_end = 1'b1;
                     repeat_in     = '0;
                     draining_in   = 1'b0;
                     load_col_in   = '0;
                  end else begin
                     repeat_in = repeat_ff + CW'(1);
                  end
               end else begin
                  drain_col_in = drain_col_ff + AW'(1);
               end
            end else begin
               copy_in = copy_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff  <= 1'b0;
         load_col_ff  <= '0;
         drain_col_ff <= '0;
         copy_ff      <= '0;
         repeat_ff    <= '0;
      end else begin
         draining_ff  <= draining_in;
         load_col_ff  <= load_col_in;
         drain_col_ff <= drain_col_in;
         copy_ff      <= copy_in;
         repeat_ff    <= repeat_in;
      end
   end

   // The store is never written while a row drains
   a_no_write_draining: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !draining_ff)
      else $error("line store written while draining");

   // The end of a group releases the store for the next row
   a_group_end_release: assert property (@(posedge clock) disable iff (reset)
      (accept && ctl.group_end) |=> (!draining_ff && load_col_ff == '0))
      else $error("group end did not release the line store");

   // Drain counters move only on an accepted word
   a_drain_hold: assert property (@(posedge clock) disable iff (reset)
      (draining_ff && !accept) |=> ($stable(drain_col_ff) && $stable(copy_ff)
                                    && $stable(repeat_ff)))
      else $error("drain counters moved without a word");

endmodule

### src/pixel_replication_upscaler_core.sv
// Top level of the pixel replication upscaler: registers, sequencer, store, result stage.
`timescale 1ns / 1ps

// Results: a result word is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while results are taken, loads and pulls alike;
// the line store has a single registered read port that each pull uses once.
// Reset: synchronous, clears the counters, the drain flag, the result stage and
// restores both registers to 1; the line store is not cleared.
module pixel_replication_upscaler_core
   import pru_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_SCALE = DEF_MAX_SCALE
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // input word channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic [CHAN_W-1:0]     req_blue_in,
   input  logic [CHAN_W-1:0]     req_green_in,
   input  logic [CHAN_W-1:0]     req_red_in,
   // result word channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [CHAN_W-1:0]     rsp_blue_out,
   output logic [CHAN_W-1:0]     rsp_green_out,
   output logic [CHAN_W-1:0]     rsp_red_out,
   output logic                  rsp_line_end,
   output logic [PAD_W-1:0]      rsp_pad_bytes,
   output logic                  rsp_group_end
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [SCALE_W-1:0] scale_factor_ff;
   logic [WIDTH_W-1:0] source_width_ff;

   logic               req_accept;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [PIXEL_W-1:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [PIXEL_W-1:0] rd_data;
   rsp_ctl_type        seq_ctl;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_ctl_type        rsp_ctl_ff;
   logic               rsp_pixel;

   // Configuration always ready; user must write only while block is idle (not enforced)
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_factor_ff <= SCALE_RESET;
         source_width_ff <= WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCALE_FACTOR: scale_factor_ff <= csr_wdata[SCALE_W-1:0];
            CSR_SOURCE_WIDTH: source_width_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Accept a new word whenever the result stage is empty or being drained,
   // so a pull can follow a pull every cycle.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   pru_seq #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE),
      .AW        (AW)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .op           (req_op),
      .pixel        ({req_red_in, req_green_in, req_blue_in}),
      .scale_factor (scale_factor_ff),
      .source_width (source_width_ff),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .ctl          (seq_ctl)
   );

   // The store read data register doubles as the pixel part of the result
   // stage: it only moves on an accepted pull, so it holds under back-pressure.
   pru_line_store #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result stage: load on accept, drop when taken, otherwise hold
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ctl_ff <= seq_ctl;
      end
   end

   // Colour bytes are zero on everything but a pixel word
   assign rsp_pixel     = (rsp_ctl_ff.kind == KIND_PIXEL);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_ctl_ff.kind;
   assign rsp_blue_out  = rsp_pixel ? rd_data[CHAN_W-1:0]          : '0;
   assign rsp_green_out = rsp_pixel ? rd_data[2*CHAN_W-1:CHAN_W]   : '0;
   assign rsp_red_out   = rsp_pixel ? rd_data[3*CHAN_W-1:2*CHAN_W] : '0;
   assign rsp_line_end  = rsp_ctl_ff.line_end;
   assign rsp_pad_bytes = rsp_ctl_ff.pad_bytes;
   assign rsp_group_end = rsp_ctl_ff.group_end;

endmodule

### tb/sv/pixel_replication_upscaler_core_test.sv
// Self-checking testbench for the pixel replication upscaler core.
`timescale 1ns / 1ps

module pixel_replication_upscaler_core_test;
   import pru_pkg::*;

   // End the run here if it has not finished.
   localparam int CYCLE_LIMIT  = 1000000;
   // Useful words (accepted loads and emitted pixels) in the random part
   localparam int RANDOM_WORDS = 700;
   // Cycles to watch for stray result words once nothing is expected
   localparam int TAIL_CYCLES  = 16;
   // Length of the long receiver hold-off
   localparam int LONG_HOLD    = 300;
   // Cap on printed mismatch lines; all of them are still counted
   localparam int PRINT_CAP    = 40;

   // One result word, field by field
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
      logic              line_end;
      logic [PAD_W-1:0]  pad;
      logic              group_end;
   } upscale_result_type;

   // Block ports, the inputs at known values from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SCALE_FACTOR;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_op = OP_LOAD;
   logic [CHAN_W-1:0]     req_blue_in = '0;
   logic [CHAN_W-1:0]     req_green_in = '0;
   logic [CHAN_W-1:0]     req_red_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [KIND_W-1:0]     rsp_kind;
   logic [CHAN_W-1:0]     rsp_blue_out;
   logic [CHAN_W-1:0]     rsp_green_out;
   logic [CHAN_W-1:0]     rsp_red_out;
   logic                  rsp_line_end;
   logic [PAD_W-1:0]      rsp_pad_bytes;
   logic                  rsp_group_end;

   // Shadow copy of the block: registers as written, line store and counters
   logic [SCALE_W-1:0]    scale_reg = SCALE_RESET;
   logic [WIDTH_W-1:0]    width_reg = WIDTH_RESET;
   logic [PIXEL_W-1:0]    store_px [0:DEF_MAX_WIDTH-1];
   int unsigned           fill_col = 0;
   int unsigned           drain_col = 0;
   int unsigned           copy_cnt = 0;
   int unsigned           repeat_cnt = 0;
   bit                    row_draining = 1'b0;

   // Result words still owed by the block, oldest first
   upscale_result_type    expected_words [$];

   // Sender burst state
   int unsigned           burst_left = 0;
   int unsigned           useful_words = 0;

   // Receiver stall state; hold_request asks for a long hold-off
   int unsigned           hold_request = 0;
   int unsigned           hold_left = 0;
   int unsigned           mode_left = 0;
   int unsigned           stall_mode = 0;
   int unsigned           stall_phase = 0;

   // Tallies
   int unsigned           mismatches = 0;
   int unsigned           cycle_count = 0;
   int unsigned           pixels_seen = 0;
   int unsigned           rows_seen = 0;
   int unsigned           groups_seen = 0;
   int unsigned           rejects_seen = 0;
   int unsigned           idle_seen = 0;
   int unsigned           reg_writes = 0;

   pixel_replication_upscaler_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_blue_in   (req_blue_in),
      .req_green_in  (req_green_in),
      .req_red_in    (req_red_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_green_out (rsp_green_out),
      .rsp_red_out   (rsp_red_out),
      .rsp_line_end  (rsp_line_end),
      .rsp_pad_bytes (rsp_pad_bytes),
      .rsp_group_end (rsp_group_end)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Work out the result of one accepted word and advance the shadow state.
   // Registers are read live, so a change between words takes effect at once.
   function automatic upscale_result_type replicate_step(input logic op,
         input logic [CHAN_W-1:0] blue, input logic [CHAN_W-1:0] green,
         input logic [CHAN_W-1:0] red);
      upscale_result_type  res;
      int unsigned         w;
      int unsigned         s;
      logic [PIXEL_W-1:0]  px;
      res = '0;
      // clamp both registers: zero acts as one, oversize acts as the maximum
      w = (width_reg == '0) ? 1 :
          (int'(width_reg) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
      s = (scale_reg == '0) ? 1 :
          (int'(scale_reg) > DEF_MAX_SCALE) ? DEF_MAX_SCALE : int'(scale_reg);
      if (op == OP_LOAD) begin
         if (row_draining) begin
            // a load during a drain is refused and changes nothing
            res.kind = KIND_REJECT;
         end else begin
            res.kind = KIND_NONE;
            store_px[fill_col] = {red, green, blue};
            if (fill_col + 1 >= w) begin
               // the last column of the row starts the drain
               row_draining = 1'b1;
               drain_col = 0;
               copy_cnt = 0;
               repeat_cnt = 0;
            end else begin
               fill_col++;
            end
         end
      end else if (row_draining) begin
         px = store_px[drain_col];
         res.kind  = KIND_PIXEL;
         res.blue  = px[CHAN_W-1:0];
         res.green = px[2*CHAN_W-1:CHAN_W];
         res.red   = px[PIXEL_W-1:2*CHAN_W];
         // compare with >= so that a lowered limit ends the run at once
         if (copy_cnt + 1 >= s) begin
            copy_cnt = 0;
            if (drain_col + 1 >= w) begin
               res.line_end = 1'b1;
               res.pad = PAD_W'((w * s) % 4);
               drain_col = 0;
               if (repeat_cnt + 1 >= s) begin
                  // last copy of the row: back to loading
                  res.group_end = 1'b1;
                  repeat_cnt = 0;
                  row_draining = 1'b0;
                  fill_col = 0;
               end else begin
                  repeat_cnt++;
               end
            end else begin
               drain_col++;
            end
         end else begin
            copy_cnt++;
         end
      end else begin
         // a pull with no row loaded yields an empty word
         res.kind = KIND_NONE;
      end
      return res;
   endfunction

   function automatic logic [CHAN_W-1:0] rand_byte();
      return CHAN_W'($urandom_range(0, 255));
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t ns mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
         input logic [7:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got 0x%02h, expected 0x%02h", name, got, want));
   endtask

   // Compare one accepted result word with the oldest expectation.
   task automatic take_result();
      upscale_result_type want;
      if (expected_words.size() == 0) begin
         flag_mismatch($sformatf("result word with nothing expected, kind %0d", rsp_kind));
      end else begin
         want = expected_words.pop_front();
         check_field("kind", 8'(rsp_kind), 8'(want.kind));
         check_field("blue_out", rsp_blue_out, want.blue);
         check_field("green_out", rsp_green_out, want.green);
         check_field("red_out", rsp_red_out, want.red);
         check_field("line_end", 8'(rsp_line_end), 8'(want.line_end));
         check_field("pad_bytes", 8'(rsp_pad_bytes), 8'(want.pad));
         check_field("group_end", 8'(rsp_group_end), 8'(want.group_end));
         case (want.kind)
            KIND_PIXEL:  pixels_seen++;
            KIND_REJECT: rejects_seen++;
            default:     idle_seen++;
         endcase
         if (want.line_end) rows_seen++;
         if (want.group_end) groups_seen++;
      end
   endtask

   // Offer one word and hold it until accepted. Start and end on a rising edge.
   // Valid stays high afterwards so that the next word can follow without a gap.
   task automatic send_word(input logic op, input logic [CHAN_W-1:0] blue,
         input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] red);
      upscale_result_type want;
      int unsigned        gap;
      if (burst_left == 0) begin
         // open a new burst, often after a gap with valid low
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_op       <= op;
      req_blue_in  <= blue;
      req_green_in <= green;
      req_red_in   <= red;
      do @(posedge clock); while (!(req_valid && req_ready));
      want = replicate_step(op, blue, green, red);
      expected_words.push_back(want);
      if (want.kind == KIND_PIXEL || (op == OP_LOAD && want.kind == KIND_NONE))
         useful_words++;
   endtask

   // Drop valid and wait on the clock, so no word is offered twice.
   task automatic req_rest();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_quiet();
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
         input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      if (idx == CSR_SCALE_FACTOR)
         scale_reg = data[SCALE_W-1:0];
      else
         width_reg = data[WIDTH_W-1:0];
      reg_writes++;
      @(posedge clock);
   endtask

   // Change one register once the block has nothing outstanding.
   task automatic retune(input logic [CSR_IDX_W-1:0] idx,
         input logic [CSR_DATA_W-1:0] data);
      req_rest();
      wait_quiet();
      write_reg(idx, data);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] scale_data,
         input logic [CSR_DATA_W-1:0] width_data);
      retune(CSR_SCALE_FACTOR, scale_data);
      retune(CSR_SOURCE_WIDTH, width_data);
   endtask

   task automatic load_row();
      while (!row_draining) send_word(OP_LOAD, rand_byte(), rand_byte(), rand_byte());
   endtask

   task automatic drain_row();
      while (row_draining) send_word(OP_PULL, rand_byte(), rand_byte(), rand_byte());
   endtask

   // Registers at their reset values: idle pull, a one-pixel row, a load
   // refused mid-drain, then the single output pixel that closes the group.
   task automatic test_idle_and_reset_values();
      send_word(OP_PULL, 8'h00, 8'hFF, 8'h00);
      send_word(OP_LOAD, 8'hA5, 8'h5A, 8'hC3);
      send_word(OP_LOAD, 8'hFF, 8'h00, 8'hFF);
      send_word(OP_PULL, 8'hFF, 8'hFF, 8'hFF);
      req_rest();
   endtask

   // Channel extremes through a three-wide row; pad of three bytes.
   task automatic test_channel_extremes();
      configure(CSR_DATA_W'(1), CSR_DATA_W'(3));
      send_word(OP_LOAD, 8'h00, 8'h00, 8'h00);
      send_word(OP_LOAD, 8'hFF, 8'hFF, 8'hFF);
      send_word(OP_LOAD, 8'h01, 8'h80, 8'h7E);
      drain_row();
      req_rest();
   endtask

   // Zero in either register acts as one.
   task automatic test_clamped_registers();
      configure(CSR_DATA_W'(0), CSR_DATA_W'(0));
      send_word(OP_LOAD, 8'h3C, 8'hC3, 8'h96);
      drain_row();
      req_rest();
   endtask

   // Registers changed part-way through a drain.
   task automatic test_live_register_change();
      // lower the scale mid-row: the current copy run ends at once
      configure(CSR_DATA_W'(3), CSR_DATA_W'(2));
      load_row();
      repeat (4) send_word(OP_PULL, rand_byte(), rand_byte(), rand_byte());
      retune(CSR_SCALE_FACTOR, CSR_DATA_W'(1));
      drain_row();
      // lower the width mid-row
      configure(CSR_DATA_W'(2), CSR_DATA_W'(3));
      load_row();
      send_word(OP_PULL, rand_byte(), rand_byte(), rand_byte());
      retune(CSR_SOURCE_WIDTH, CSR_DATA_W'(1));
      drain_row();
      // raise the width mid-row; columns one and two hold the previous row
      configure(CSR_DATA_W'(2), CSR_DATA_W'(1));
      load_row();
      send_word(OP_PULL, rand_byte(), rand_byte(), rand_byte());
      retune(CSR_SOURCE_WIDTH, CSR_DATA_W'(3));
      drain_row();
      req_rest();
   endtask

   // Oversize register values clamp to the store depth and the scale limit.
   task automatic test_extreme_settings();
      // an oversize width keeps the row open; narrow it so the next load closes it
      configure(CSR_DATA_W'(1), CSR_DATA_W'(2047));
      repeat (8) send_word(OP_LOAD, rand_byte(), rand_byte(), rand_byte());
      retune(CSR_SOURCE_WIDTH, CSR_DATA_W'(4));
      load_row();
      drain_row();
      // all ones on the scale write: upper bits drop, 127 clamps to the limit,
      // so the first row end comes on the last of the limit's pulls; a scale
      // of one then closes the group
      configure(CSR_DATA_W'(2047), CSR_DATA_W'(1));
      load_row();
      repeat (DEF_MAX_SCALE) send_word(OP_PULL, rand_byte(), rand_byte(), rand_byte());
      retune(CSR_SCALE_FACTOR, CSR_DATA_W'(1));
      drain_row();
      req_rest();
   endtask

   // Hold the result side off for a long stretch while words keep coming,
   // so the block fills and stalls its input.
   task automatic test_full_result_stall();
      configure(CSR_DATA_W'(2), CSR_DATA_W'(3));
      hold_request = LONG_HOLD;
      load_row();
      drain_row();
      req_rest();
   endtask

   // Mostly well-formed rows with random content and settings, with refused
   // loads and idle pulls mixed in, plus some runs of random words.
   task automatic test_random_rows();
      int unsigned s;
      int unsigned w;
      useful_words = 0;
      while (useful_words < RANDOM_WORDS) begin
         if (!row_draining && $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 9))
               0: begin
                  s = 0;
                  w = $urandom_range(0, 12);
               end
               1: begin
                  s = $urandom_range(5, 8);
                  w = $urandom_range(1, 3);
               end
               2: begin
                  s = 1;
                  w = $urandom_range(16, 64);
               end
               default: begin
                  s = $urandom_range(1, 4);
                  w = $urandom_range(1, 8);
               end
            endcase
            // junk in the upper bits of a scale write must be ignored
            configure({4'($urandom_range(0, 15)), 7'(s)}, CSR_DATA_W'(w));
         end
         if ($urandom_range(0, 4) != 0) begin
            while (!row_draining) begin
               if ($urandom_range(0, 9) == 0)
                  send_word(OP_PULL, rand_byte(), rand_byte(), rand_byte());
               else
                  send_word(OP_LOAD, rand_byte(), rand_byte(), rand_byte());
            end
            while (row_draining) begin
               if ($urandom_range(0, 11) == 0)
                  send_word(OP_LOAD, rand_byte(), rand_byte(), rand_byte());
               else
                  send_word(OP_PULL, rand_byte(), rand_byte(), rand_byte());
            end
         end else begin
            repeat ($urandom_range(1, 10))
               send_word(1'($urandom_range(0, 1)), rand_byte(), rand_byte(), rand_byte());
         end
      end
      req_rest();
   endtask

   // Result side: take and check words, stall on a pattern of its own that
   // changes every so often, and honour a requested long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) take_result();
         if (hold_left == 0 && hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 200);
            stall_mode = $urandom_range(0, 3);
         end
         mode_left--;
         stall_phase++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= (stall_phase % 4 == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d words outstanding",
                  cycle_count, expected_words.size());
         $display("pixel_replication_upscaler_core_test: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_and_reset_values();
      test_channel_extremes();
      test_clamped_registers();
      test_live_register_change();
      test_extreme_settings();
      test_full_result_stall();
      test_random_rows();
      // drain what is owed, then watch for stray words
      req_rest();
      wait_quiet();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("checked %0d pixels in %0d output rows and %0d row groups", pixels_seen,
               rows_seen, groups_seen);
      $display("also %0d refused loads, %0d empty words, %0d register writes, %0d errors",
               rejects_seen, idle_seen, reg_writes, mismatches);
      if (mismatches == 0)
         $display("pixel_replication_upscaler_core_test: PASS");
      else
         $display("pixel_replication_upscaler_core_test: FAIL");
      $finish;
   end

endmodule

### pixel_replication_upscaler_core.f
src/pru_pkg.sv
src/pru_line_store.sv
src/pru_seq.sv
src/pixel_replication_upscaler_core.sv
tb/sv/pixel_replication_upscaler_core_test.sv
